// ----- hdl/mmp_pkg.sv -----
// shared types, message codes and lookup functions for the midi message parser
package mmp_pkg;

  // high nibble of a status byte
  localparam logic [3:0] TYPE_NOTE_OFF   = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON    = 4'h9;
  localparam logic [3:0] TYPE_AFTERTOUCH = 4'hA;
  localparam logic [3:0] TYPE_CTRL       = 4'hB;
  localparam logic [3:0] TYPE_PROGRAM    = 4'hC;
  localparam logic [3:0] TYPE_PRESSURE   = 4'hD;
  localparam logic [3:0] TYPE_BEND       = 4'hE;
  localparam logic [3:0] TYPE_SYSTEM     = 4'hF;

  // data byte counts of a frame
  localparam logic [1:0] COUNT_ONE = 2'd1;
  localparam logic [1:0] COUNT_TWO = 2'd2;

  // reported message kinds
  typedef enum logic [1:0] {
    KIND_NOTE_OFF = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_CTRL     = 2'd2,
    KIND_PROGRAM  = 2'd3
  } msg_kind_t;

  // parser state that reset clears
  typedef struct packed {
    logic       in_frame;
    logic [3:0] running_type;
    logic       running_valid;
    logic [3:0] running_channel;
    logic [1:0] bytes_needed;
    logic [1:0] bytes_seen;
  } parse_state_t;

  // one result item
  typedef struct packed {
    msg_kind_t  msg_kind;
    logic [3:0] msg_channel;
    logic [6:0] first_data;
    logic [6:0] second_data;
  } msg_t;

  // kind lookup with a flag for types that are reported
  typedef struct packed {
    logic      reported;
    msg_kind_t kind;
  } kind_map_t;

  // data bytes taken by a channel message type
  function automatic logic [1:0] data_count(input logic [3:0] msg_type);
    logic [1:0] cnt;
    cnt = ((msg_type == TYPE_PROGRAM) || (msg_type == TYPE_PRESSURE)) ? COUNT_ONE : COUNT_TWO;
    return cnt;
  endfunction

  // map a message type onto its reported kind
  function automatic kind_map_t kind_of(input logic [3:0] msg_type);
    kind_map_t km;
    km.reported = 1'b1;
    km.kind     = KIND_NOTE_OFF;
    unique case (msg_type)
      TYPE_NOTE_OFF: km.kind = KIND_NOTE_OFF;
      TYPE_NOTE_ON:  km.kind = KIND_NOTE_ON;
      TYPE_CTRL:     km.kind = KIND_CTRL;
      TYPE_PROGRAM:  km.kind = KIND_PROGRAM;
      default:       km.reported = 1'b0;
    endcase
    return km;
  endfunction

endpackage

// ----- hdl/mmp_if.sv -----
// valid/ready channel interfaces for received bytes and parsed messages
interface mmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mmp_msg_if;
  logic       valid;
  logic       ready;
  logic [1:0] msg_kind;
  logic [3:0] msg_channel;
  logic [6:0] first_data;
  logic [6:0] second_data;

  modport source (output valid, output msg_kind, output msg_channel,
                  output first_data, output second_data, input ready);
  modport sink   (input valid, input msg_kind, input msg_channel,
                  input first_data, input second_data, output ready);
endinterface

// ----- hdl/mmp_frame_decode.sv -----
// combinational frame decoder: next parser state and result for one byte
module mmp_frame_decode
  import mmp_pkg::*;
(
  input  logic [7:0]   rx_byte,
  input  parse_state_t state,
  input  logic [6:0]   held_data,
  output parse_state_t state_nxt,
  output logic         held_we,
  output logic [6:0]   held_nxt,
  output logic         res_vld,
  output msg_t         res
);

  logic [3:0] byte_type;
  logic [6:0] data;
  logic [1:0] eff_needed;
  logic [1:0] eff_seen;
  kind_map_t  km;

  assign byte_type = rx_byte[7:4];
  assign data      = rx_byte[6:0];
  assign held_nxt  = data;

  // a data byte outside a frame opens a new one from running status
  assign eff_needed = state.in_frame ? state.bytes_needed : data_count(state.running_type);
  assign eff_seen   = state.in_frame ? state.bytes_seen : 2'd0;
  assign km         = kind_of(state.running_type);

  // state update and result selection
  always_comb begin
    state_nxt       = state;
    held_we         = 1'b0;
    res_vld         = 1'b0;
    res.msg_kind    = km.kind;
    res.msg_channel = state.running_channel;
    res.first_data  = data;
    res.second_data = 7'd0;
    if (rx_byte[7]) begin
      if (byte_type == TYPE_SYSTEM) begin
        // system status drops running status and any open frame
        state_nxt.running_valid = 1'b0;
        state_nxt.in_frame      = 1'b0;
        state_nxt.bytes_seen    = 2'd0;
      end else begin
        state_nxt.running_type    = byte_type;
        state_nxt.running_channel = rx_byte[3:0];
        state_nxt.running_valid   = 1'b1;
        state_nxt.in_frame        = 1'b1;
        state_nxt.bytes_needed    = data_count(byte_type);
        state_nxt.bytes_seen      = 2'd0;
      end
    end else if (state.in_frame || state.running_valid) begin
      state_nxt.bytes_needed = eff_needed;
      if ((eff_seen == 2'd0) && (eff_needed == COUNT_TWO)) begin
        // first of two data bytes is held
        state_nxt.in_frame   = 1'b1;
        state_nxt.bytes_seen = 2'd1;
        held_we              = 1'b1;
      end else begin
        // frame complete
        state_nxt.in_frame   = 1'b0;
        state_nxt.bytes_seen = 2'd0;
        res_vld              = km.reported;
        if (eff_seen != 2'd0) begin
          res.first_data  = held_data;
          res.second_data = data;
        end
        if (km.kind == KIND_PROGRAM) begin
          res.second_data = 7'd0;
        end
      end
    end
  end

endmodule

// ----- hdl/midi_message_parser.sv -----
// midi message parser: running status byte stream to note, control and program messages
// an accepted byte passes through the input register, then the result register
// one byte per cycle when not stalled; parser state updates in a single pass per byte
// a full result register stalls the byte stage only while the result is not taken
// reset (synchronous, active low) clears running status, frame state and both valid flags
module midi_message_parser
  import mmp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  mmp_byte_if.sink   in_ch,
  mmp_msg_if.source  out_ch
);

  logic         in_vld_r;
  logic [7:0]   in_byte_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  logic [6:0]   held_r;
  logic         held_we;
  logic [6:0]   held_nxt;
  logic         res_vld;
  msg_t         res;
  logic         out_vld_r;
  msg_t         out_r;
  logic         advance;
  logic         process;

  // byte stage moves on when the result register is free or being drained
  assign advance     = !out_vld_r || out_ch.ready;
  assign process     = in_vld_r && advance;
  assign in_ch.ready = !in_vld_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  // frame decode
  mmp_frame_decode u_decode (
    .rx_byte   (in_byte_r),
    .state     (state_r),
    .held_data (held_r),
    .state_nxt (state_nxt),
    .held_we   (held_we),
    .held_nxt  (held_nxt),
    .res_vld   (res_vld),
    .res       (res)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (process) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (process && held_we) begin
      held_r <= held_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= process && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (process && res_vld) begin
      out_r <= res;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.msg_kind    = out_r.msg_kind;
  assign out_ch.msg_channel = out_r.msg_channel;
  assign out_ch.first_data  = out_r.first_data;
  assign out_ch.second_data = out_r.second_data;

  // a program change never carries a second data byte
  a_program_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_r.msg_kind == KIND_PROGRAM)) |-> (out_r.second_data == 7'd0))
    else $error("program change result with non-zero second data");

  // a held first byte only exists inside an open frame
  a_seen_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.bytes_seen != 2'd0) |-> state_r.in_frame)
    else $error("data byte counted outside a frame");

  // at most one data byte is ever held
  a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.bytes_seen == 2'd0) || (state_r.bytes_seen == 2'd1))
    else $error("bytes_seen out of range");

  // an open frame always has running status behind it
  a_frame_has_status: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.in_frame |-> state_r.running_valid)
    else $error("frame open without running status");

  // a completed reported frame lands in the result register
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (process && res_vld) |=> out_vld_r)
    else $error("completed frame did not produce a result");

endmodule

// ----- tb/tb_midi_message_parser.sv -----
// self-checking testbench for the midi message parser with its own running status decoder
module tb_midi_message_parser
  import mmp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n;

  mmp_byte_if byte_ch ();
  mmp_msg_if  msg_ch ();

  midi_message_parser uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (byte_ch.sink),
    .out_ch (msg_ch.source)
  );

  // decoder copy of the parser state
  logic       in_frame;
  logic [3:0] run_type;
  logic       run_valid;
  logic [3:0] run_chan;
  logic [1:0] need;
  logic [1:0] seen;
  logic [6:0] held;

  msg_t msgs_due[$];
  int   bytes_sent = 0;
  int   errors = 0;
  bit   calm = 1'b0;

  always #5 clk = ~clk;

  // data bytes a channel message type takes
  function automatic logic [1:0] frame_len(input logic [3:0] kind_nib);
    if (kind_nib == TYPE_PROGRAM || kind_nib == TYPE_PRESSURE) return COUNT_ONE;
    return COUNT_TWO;
  endfunction

  // advance the decoder by one accepted byte and queue any message it completes
  function automatic void decode_byte(input logic [7:0] b);
    logic [6:0] first;
    logic [6:0] second;
    msg_t       m;
    if (b[7]) begin
      if (b[7:4] == TYPE_SYSTEM) begin
        run_valid = 1'b0;
        in_frame  = 1'b0;
        seen      = 2'd0;
      end else begin
        run_type  = b[7:4];
        run_chan  = b[3:0];
        run_valid = 1'b1;
        in_frame  = 1'b1;
        need      = frame_len(b[7:4]);
        seen      = 2'd0;
      end
      return;
    end
    // running status opens a new frame
    if (!in_frame) begin
      if (!run_valid) return;
      in_frame = 1'b1;
      need     = frame_len(run_type);
      seen     = 2'd0;
    end
    if (seen == 2'd0 && need == COUNT_TWO) begin
      held = b[6:0];
      seen = 2'd1;
      return;
    end
    if (seen == 2'd0) begin
      first  = b[6:0];
      second = 7'd0;
    end else begin
      first  = held;
      second = b[6:0];
    end
    in_frame = 1'b0;
    seen     = 2'd0;
    case (run_type)
      TYPE_NOTE_OFF: m.msg_kind = KIND_NOTE_OFF;
      TYPE_NOTE_ON:  m.msg_kind = KIND_NOTE_ON;
      TYPE_CTRL:     m.msg_kind = KIND_CTRL;
      TYPE_PROGRAM: begin
        m.msg_kind = KIND_PROGRAM;
        second     = 7'd0;
      end
      default: return;
    endcase
    m.msg_channel = run_chan;
    m.first_data  = first;
    m.second_data = second;
    msgs_due.push_back(m);
  endfunction

  // present one byte, with random idle cycles ahead of it, until it is taken
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 30) begin
      byte_ch.valid = 1'b0;
      @(negedge clk);
    end
    byte_ch.valid   = 1'b1;
    byte_ch.rx_byte = b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    decode_byte(b);
    bytes_sent++;
  endtask

  // stop sending and hold off until every queued message has come out
  task automatic wait_drained();
    @(negedge clk);
    byte_ch.valid = 1'b0;
    while (msgs_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // data with no status seen since reset
  task automatic test_no_status();
    send_byte(8'h40);
  endtask

  // reported messages, extremes of channel and data, running status
  task automatic test_channel_messages();
    send_byte(8'h90); send_byte(8'h00); send_byte(8'h7F);
    send_byte(8'h7F); send_byte(8'h00);
    send_byte(8'h8F); send_byte(8'h3C); send_byte(8'h40);
    send_byte(8'hB7); send_byte(8'h07); send_byte(8'h64);
    send_byte(8'hC5); send_byte(8'h12); send_byte(8'h13);
  endtask

  // aftertouch, channel pressure and pitch bend are taken but not reported
  task automatic test_silent_frames();
    send_byte(8'hA2); send_byte(8'h10); send_byte(8'h20);
    send_byte(8'hD3); send_byte(8'h55);
    send_byte(8'hE1); send_byte(8'h00);
  endtask

  // system byte drops the open bend frame and running status
  task automatic test_system_status();
    send_byte(8'hFF); send_byte(8'h40);
  endtask

  // a new status inside a frame restarts it
  task automatic test_status_mid_frame();
    send_byte(8'h93); send_byte(8'h30);
    send_byte(8'h85); send_byte(8'h31); send_byte(8'h32);
  endtask

  // mostly well-formed frames with random content, plus noise and cut frames
  task automatic test_random_stream();
    int         start;
    int         pick;
    logic [3:0] kind_nib;
    logic [1:0] n;
    start = bytes_sent;
    while (bytes_sent - start < 1920) begin
      calm = (bytes_sent - start >= 700) && (bytes_sent - start < 1000);
      pick = $urandom_range(99);
      if (pick < 70) begin
        if (run_valid && !in_frame && $urandom_range(1) == 1) begin
          kind_nib = run_type;
        end else begin
          kind_nib = 4'($urandom_range(8, 14));
          send_byte({kind_nib, 4'($urandom_range(15))});
        end
        n = frame_len(kind_nib);
        repeat (n) send_byte({1'b0, 7'($urandom_range(127))});
      end else if (pick < 85) begin
        send_byte({1'b0, 7'($urandom_range(127))});
      end else if (pick < 95) begin
        send_byte({4'($urandom_range(8, 14)), 4'($urandom_range(15))});
        send_byte({1'b0, 7'($urandom_range(127))});
      end else begin
        send_byte({4'hF, 4'($urandom_range(15))});
      end
    end
    calm = 1'b0;
  endtask

  // result side back-pressure
  initial begin
    msg_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      msg_ch.ready = calm || ($urandom_range(99) >= 30);
    end
  end

  // compare each taken message with the oldest one due
  always @(posedge clk) begin
    msg_t want;
    if (rst_n && msg_ch.valid && msg_ch.ready) begin
      if (msgs_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected message kind %0d ch %0d data %0d %0d", $realtime,
                   msg_ch.msg_kind, msg_ch.msg_channel, msg_ch.first_data,
                   msg_ch.second_data);
      end else begin
        want = msgs_due.pop_front();
        if (msg_ch.msg_kind !== want.msg_kind || msg_ch.msg_channel !== want.msg_channel ||
            msg_ch.first_data !== want.first_data ||
            msg_ch.second_data !== want.second_data) begin
          errors++;
          if (errors <= 10)
            $display("%0t: message mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     $realtime, want.msg_kind, want.msg_channel, want.first_data,
                     want.second_data, msg_ch.msg_kind, msg_ch.msg_channel,
                     msg_ch.first_data, msg_ch.second_data);
        end
      end
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // test sequence
  initial begin
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = 8'h00;
    rst_n           = 1'b0;
    in_frame  = 1'b0;
    run_type  = 4'h0;
    run_valid = 1'b0;
    run_chan  = 4'h0;
    need      = 2'd0;
    seen      = 2'd0;
    held      = 7'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_no_status();
    test_channel_messages();
    wait_drained();
    test_silent_frames();
    test_system_status();
    test_status_mid_frame();
    wait_drained();
    test_random_stream();
    wait_drained();
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
